[hdl/mcar_pkg.sv]
// Shared types, codes and point mirroring for the midpoint circle arc rasterizer.
package mcar_pkg;

  localparam int unsigned CoordW  = 10;
  localparam int unsigned StepW   = 11;
  localparam int unsigned EdgeW   = 12;
  localparam int unsigned DecW    = 16;
  localparam int unsigned ColourW = 6;
  localparam int unsigned ClipW   = 11;
  localparam int unsigned NumOct  = 8;
  localparam int unsigned OctW    = 3;
  localparam int unsigned QDepth  = 2;

  localparam logic [ClipW-1:0] ClipMaxXReset = 11'd800;
  localparam logic [ClipW-1:0] ClipMaxYReset = 11'd480;

  typedef enum logic [1:0] {
    KIND_EMPTY = 2'd0,
    KIND_PIXEL = 2'd1,
    KIND_LINE  = 2'd2
  } kind_e;

  typedef enum logic {
    CMD_START   = 1'b0,
    CMD_ADVANCE = 1'b1
  } cmd_e;

  typedef enum logic {
    REG_CLIP_MAX_X = 1'b0,
    REG_CLIP_MAX_Y = 1'b1
  } reg_e;

  // One step's worth of work handed from the front to the back
  typedef struct packed {
    logic [CoordW-1:0]  cx;
    logic [CoordW-1:0]  cy;
    logic [StepW-1:0]   a;
    logic [StepW-1:0]   b;
    logic [ColourW-1:0] colour;
    logic               fill;
    logic [NumOct-1:0]  mask;
    logic               fin;
    logic               blank;
  } job_t;

  function automatic logic [EdgeW-1:0] mcar_point_x(
    input logic [OctW-1:0]   k,
    input logic [CoordW-1:0] cx,
    input logic [StepW-1:0]  a,
    input logic [StepW-1:0]  b
  );
    logic [EdgeW-1:0] cxs;
    logic [EdgeW-1:0] as;
    logic [EdgeW-1:0] bs;
    logic [EdgeW-1:0] res;
    cxs = {2'b00, cx};
    as  = {1'b0, a};
    bs  = {b[StepW-1], b};
    case (k)
      3'd0, 3'd2: res = cxs + as;
      3'd1, 3'd3: res = cxs - as;
      3'd4, 3'd6: res = cxs - bs;
      3'd5, 3'd7: res = cxs + bs;
      default:    res = cxs;
    endcase
    return res;
  endfunction

  function automatic logic [EdgeW-1:0] mcar_point_y(
    input logic [OctW-1:0]   k,
    input logic [CoordW-1:0] cy,
    input logic [StepW-1:0]  a,
    input logic [StepW-1:0]  b
  );
    logic [EdgeW-1:0] cys;
    logic [EdgeW-1:0] as;
    logic [EdgeW-1:0] bs;
    logic [EdgeW-1:0] res;
    cys = {2'b00, cy};
    as  = {1'b0, a};
    bs  = {b[StepW-1], b};
    case (k)
      3'd0, 3'd1: res = cys + bs;
      3'd2, 3'd3: res = cys - bs;
      3'd4, 3'd5: res = cys - as;
      3'd6, 3'd7: res = cys + as;
      default:    res = cys;
    endcase
    return res;
  endfunction

endpackage

[hdl/midpoint_circle_arc_rasterizer_top.sv]
// Top level of the midpoint circle arc rasterizer.
// Input channel (in_valid_i / in_stall_o): a start item loads centre, radius, colour,
// fill mode and octant mask; an advance item takes one midpoint step.
// Output channel (out_valid_o / out_stall_i): one draw command per item transfer,
// pixel or radial line, octants in ascending order, last set on the final one of a
// step. A step that draws nothing, or an advance once done, gives one empty item.
// The front end updates the circle state in the cycle an item is taken and pushes a
// job into a two-entry queue; the back end walks the enabled octants, one command
// per cycle unless out_stall_i holds the result register.
// Throughput is set by the single result port: each item gives one command per
// enabled-and-kept octant, or one empty command if none, 8 for a full circle kept whole.
// in_stall_o rises only when the job queue is full.
// When out_stall_i is high the result register holds its command; the back end and
// then the queue fill, and stall propagates to the input.
// Reset clears the queue, the result valid flag and the circle state (done set) and
// loads clip limits of 800 by 480. Clip registers sit at APB byte addresses 0 and 4;
// the user must write them only while the block is idle; the block does not enforce it.
module midpoint_circle_arc_rasterizer_top #(
  parameter int unsigned MAX_RADIUS = 1023
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         cmd_i,
  input  logic [mcar_pkg::CoordW-1:0]  centre_x_i,
  input  logic [mcar_pkg::CoordW-1:0]  centre_y_i,
  input  logic [mcar_pkg::CoordW-1:0]  radius_i,
  input  logic [mcar_pkg::ColourW-1:0] colour_i,
  input  logic                         fill_i,
  input  logic [mcar_pkg::NumOct-1:0]  octant_mask_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   kind_o,
  output logic [mcar_pkg::OctW-1:0]    octant_o,
  output logic [mcar_pkg::EdgeW-1:0]   edge_x_o,
  output logic [mcar_pkg::EdgeW-1:0]   edge_y_o,
  output logic [mcar_pkg::CoordW-1:0]  to_x_o,
  output logic [mcar_pkg::CoordW-1:0]  to_y_o,
  output logic [mcar_pkg::ColourW-1:0] out_colour_o,
  output logic                         last_o,
  output logic                         done_res_o
);
  import mcar_pkg::*;

  logic [ClipW-1:0] clip_x_q;
  logic [ClipW-1:0] clip_y_q;
  logic             wr_en;
  reg_e             reg_sel;

  logic push;
  logic pop;
  logic full;
  logic head_valid;
  job_t job_in;
  job_t job_head;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = reg_e'(paddr[2]);

  always_comb begin
    case (reg_sel)
      REG_CLIP_MAX_X: prdata = {{(32-ClipW){1'b0}}, clip_x_q};
      REG_CLIP_MAX_Y: prdata = {{(32-ClipW){1'b0}}, clip_y_q};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_x_q <= ClipMaxXReset;
      clip_y_q <= ClipMaxYReset;
    end else if (wr_en) begin
      if (reg_sel == REG_CLIP_MAX_X) begin
        clip_x_q <= pwdata[ClipW-1:0];
      end
      if (reg_sel == REG_CLIP_MAX_Y) begin
        clip_y_q <= pwdata[ClipW-1:0];
      end
    end
  end

  mcar_front #(
    .MAX_RADIUS(MAX_RADIUS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .centre_x_i   (centre_x_i),
    .centre_y_i   (centre_y_i),
    .radius_i     (radius_i),
    .colour_i     (colour_i),
    .fill_i       (fill_i),
    .octant_mask_i(octant_mask_i),
    .push_o       (push),
    .job_o        (job_in),
    .full_i       (full)
  );

  mcar_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (job_in),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(head_valid),
    .data_o (job_head)
  );

  mcar_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (head_valid),
    .job_i       (job_head),
    .pop_o       (pop),
    .clip_max_x_i(clip_x_q),
    .clip_max_y_i(clip_y_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .octant_o    (octant_o),
    .edge_x_o    (edge_x_o),
    .edge_y_o    (edge_y_o),
    .to_x_o      (to_x_o),
    .to_y_o      (to_y_o),
    .out_colour_o(out_colour_o),
    .last_o      (last_o),
    .done_res_o  (done_res_o)
  );

endmodule

[hdl/mcar_front.sv]
// Front end: accepts items, advances the midpoint decision state, issues jobs.
module mcar_front #(
  parameter int unsigned MAX_RADIUS = 1023
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        cmd_i,
  input  logic [mcar_pkg::CoordW-1:0] centre_x_i,
  input  logic [mcar_pkg::CoordW-1:0] centre_y_i,
  input  logic [mcar_pkg::CoordW-1:0] radius_i,
  input  logic [mcar_pkg::ColourW-1:0] colour_i,
  input  logic                        fill_i,
  input  logic [mcar_pkg::NumOct-1:0] octant_mask_i,
  output logic                        push_o,
  output mcar_pkg::job_t              job_o,
  input  logic                        full_i
);
  import mcar_pkg::*;

  localparam logic [CoordW+1:0] RadMax = (CoordW + 2)'(MAX_RADIUS);

  logic [CoordW-1:0]  cx_q, cx_d;
  logic [CoordW-1:0]  cy_q, cy_d;
  logic [StepW-1:0]   x_q, x_d;
  logic [StepW-1:0]   y_q, y_d;
  logic [DecW-1:0]    dec_q, dec_d;
  logic [ColourW-1:0] col_q, col_d;
  logic               fill_q, fill_d;
  logic [NumOct-1:0]  mask_q, mask_d;
  logic               fin_q, fin_d;

  logic               accept;
  logic [CoordW-1:0]  r_sat;
  logic [StepW-1:0]   x1;
  logic [StepW-1:0]   y1;
  logic [EdgeW-1:0]   diff;
  logic [DecW-1:0]    diff4;
  logic [DecW-1:0]    x4;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i & ~full_i;
  assign r_sat      = ({2'b00, radius_i} > RadMax) ? CoordW'(MAX_RADIUS) : radius_i;

  always_comb begin
    x1    = x_q + StepW'(1);
    y1    = ($signed(dec_q) > 0) ? (y_q - StepW'(1)) : y_q;
    diff  = {1'b0, x1} - {y1[StepW-1], y1};
    diff4 = {{(DecW-EdgeW){diff[EdgeW-1]}}, diff} << 2;
    x4    = {{(DecW-StepW){1'b0}}, x1} << 2;
  end

  always_comb begin
    cx_d   = cx_q;
    cy_d   = cy_q;
    x_d    = x_q;
    y_d    = y_q;
    dec_d  = dec_q;
    col_d  = col_q;
    fill_d = fill_q;
    mask_d = mask_q;
    fin_d  = fin_q;
    if (accept) begin
      if (cmd_i == CMD_START) begin
        cx_d   = centre_x_i;
        cy_d   = centre_y_i;
        x_d    = '0;
        y_d    = {1'b0, r_sat};
        dec_d  = DecW'(3) - {{(DecW-CoordW-1){1'b0}}, r_sat, 1'b0};
        col_d  = colour_i;
        fill_d = fill_i;
        mask_d = octant_mask_i;
        fin_d  = 1'b0;
      end else if (!fin_q) begin
        x_d = x1;
        y_d = y1;
        if ($signed(dec_q) > 0) begin
          dec_d = dec_q + diff4 + DecW'(10);
        end else begin
          dec_d = dec_q + x4 + DecW'(6);
        end
        fin_d = $signed({y1[StepW-1], y1}) < $signed({1'b0, x1});
      end
    end
  end

  always_comb begin
    push_o       = accept;
    job_o.cx     = cx_d;
    job_o.cy     = cy_d;
    job_o.a      = x_d;
    job_o.b      = y_d;
    job_o.colour = col_d;
    job_o.fill   = fill_d;
    job_o.mask   = mask_d;
    job_o.fin    = fin_d;
    job_o.blank  = (cmd_i == CMD_ADVANCE) & fin_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q   <= '0;
      cy_q   <= '0;
      x_q    <= '0;
      y_q    <= '0;
      dec_q  <= '0;
      col_q  <= '0;
      fill_q <= 1'b0;
      mask_q <= '0;
      fin_q  <= 1'b1;
    end else begin
      cx_q   <= cx_d;
      cy_q   <= cy_d;
      x_q    <= x_d;
      y_q    <= y_d;
      dec_q  <= dec_d;
      col_q  <= col_d;
      fill_q <= fill_d;
      mask_q <= mask_d;
      fin_q  <= fin_d;
    end
  end

endmodule

[hdl/mcar_fifo.sv]
// Short job queue between the front end and the back end.
module mcar_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mcar_pkg::job_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output mcar_pkg::job_t data_o
);
  import mcar_pkg::*;

  localparam int unsigned PtrW = $clog2(QDepth);

  job_t            mem_q [QDepth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [PtrW:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (PtrW + 1)'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + (PtrW + 1)'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - (PtrW + 1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

[hdl/mcar_back.sv]
// Back end: walks the enabled octants of a job and drives the result register.
module mcar_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         job_valid_i,
  input  mcar_pkg::job_t               job_i,
  output logic                         pop_o,
  input  logic [mcar_pkg::ClipW-1:0]   clip_max_x_i,
  input  logic [mcar_pkg::ClipW-1:0]   clip_max_y_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   kind_o,
  output logic [mcar_pkg::OctW-1:0]    octant_o,
  output logic [mcar_pkg::EdgeW-1:0]   edge_x_o,
  output logic [mcar_pkg::EdgeW-1:0]   edge_y_o,
  output logic [mcar_pkg::CoordW-1:0]  to_x_o,
  output logic [mcar_pkg::CoordW-1:0]  to_y_o,
  output logic [mcar_pkg::ColourW-1:0] out_colour_o,
  output logic                         last_o,
  output logic                         done_res_o
);
  import mcar_pkg::*;

  job_t              work_q, work_d;
  logic              busy_q, busy_d;
  logic [NumOct-1:0] pend_q, pend_d;
  logic              ov_q, ov_d;

  kind_e              kind_q, kind_d;
  logic [OctW-1:0]    oct_q, oct_d;
  logic [EdgeW-1:0]   ex_q, ex_d;
  logic [EdgeW-1:0]   ey_q, ey_d;
  logic [CoordW-1:0]  tx_q, tx_d;
  logic [CoordW-1:0]  ty_q, ty_d;
  logic [ColourW-1:0] col_q, col_d;
  logic               last_q, last_d;
  logic               done_q, done_d;

  logic              adv;
  logic [NumOct-1:0] head_pend;
  logic [OctW-1:0]   sel;
  logic [NumOct-1:0] sel_bit;
  logic              fin_item;
  logic              load;

  // Work out which octants of the queued job produce a command
  always_comb begin
    logic [EdgeW-1:0] px;
    logic [EdgeW-1:0] py;
    logic             ok;
    logic             c_ok;
    c_ok = ({1'b0, job_i.cx} <= clip_max_x_i) && ({1'b0, job_i.cy} <= clip_max_y_i);
    for (int k = 0; k < NumOct; k++) begin
      px = mcar_point_x(OctW'(k), job_i.cx, job_i.a, job_i.b);
      py = mcar_point_y(OctW'(k), job_i.cy, job_i.a, job_i.b);
      ok = !px[EdgeW-1] && (px[EdgeW-2:0] <= clip_max_x_i) &&
           !py[EdgeW-1] && (py[EdgeW-2:0] <= clip_max_y_i) && c_ok;
      head_pend[k] = job_i.mask[k] & (ok | ~job_i.fill) & ~job_i.blank;
    end
  end

  always_comb begin
    logic found;
    found = 1'b0;
    sel   = '0;
    for (int k = 0; k < NumOct; k++) begin
      if (pend_q[k] && !found) begin
        sel   = OctW'(k);
        found = 1'b1;
      end
    end
    sel_bit = NumOct'(1) << sel;
  end

  assign adv      = ~ov_q | ~out_stall_i;
  assign fin_item = (pend_q == '0) || ((pend_q & ~sel_bit) == '0);
  assign load     = ~busy_q | (adv & fin_item);
  assign pop_o    = load & job_valid_i;

  always_comb begin
    work_d = work_q;
    busy_d = busy_q;
    pend_d = pend_q;
    if (busy_q && adv) begin
      pend_d = pend_q & ~sel_bit;
    end
    if (load) begin
      busy_d = job_valid_i;
      if (job_valid_i) begin
        work_d = job_i;
        pend_d = head_pend;
      end
    end
  end

  always_comb begin
    ov_d   = ov_q;
    kind_d = kind_q;
    oct_d  = oct_q;
    ex_d   = ex_q;
    ey_d   = ey_q;
    tx_d   = tx_q;
    ty_d   = ty_q;
    col_d  = col_q;
    last_d = last_q;
    done_d = done_q;
    if (adv) begin
      ov_d   = busy_q;
      last_d = fin_item;
      done_d = work_q.fin;
      if (pend_q == '0) begin
        kind_d = KIND_EMPTY;
        oct_d  = '0;
        ex_d   = '0;
        ey_d   = '0;
        tx_d   = '0;
        ty_d   = '0;
        col_d  = '0;
      end else begin
        kind_d = work_q.fill ? KIND_LINE : KIND_PIXEL;
        oct_d  = sel;
        ex_d   = mcar_point_x(sel, work_q.cx, work_q.a, work_q.b);
        ey_d   = mcar_point_y(sel, work_q.cy, work_q.a, work_q.b);
        tx_d   = work_q.fill ? work_q.cx : '0;
        ty_d   = work_q.fill ? work_q.cy : '0;
        col_d  = work_q.colour;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    kind_q <= kind_d;
    oct_q  <= oct_d;
    ex_q   <= ex_d;
    ey_q   <= ey_d;
    tx_q   <= tx_d;
    ty_q   <= ty_d;
    col_q  <= col_d;
    last_q <= last_d;
    done_q <= done_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pend_q <= '0;
      ov_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      pend_q <= pend_d;
      ov_q   <= ov_d;
    end
  end

  assign out_valid_o  = ov_q;
  assign kind_o       = kind_q;
  assign octant_o     = oct_q;
  assign edge_x_o     = ex_q;
  assign edge_y_o     = ey_q;
  assign to_x_o       = tx_q;
  assign to_y_o       = ty_q;
  assign out_colour_o = col_q;
  assign last_o       = last_q;
  assign done_res_o   = done_q;

endmodule

[hdl/mcar_checker.sv]
// Port-level checks for the rasterizer top level, and their binding.
module mcar_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [1:0]                   kind_o,
  input logic [mcar_pkg::OctW-1:0]    octant_o,
  input logic [mcar_pkg::EdgeW-1:0]   edge_x_o,
  input logic [mcar_pkg::EdgeW-1:0]   edge_y_o,
  input logic [mcar_pkg::CoordW-1:0]  to_x_o,
  input logic [mcar_pkg::CoordW-1:0]  to_y_o,
  input logic [mcar_pkg::ColourW-1:0] out_colour_o,
  input logic                         last_o
);
  import mcar_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) &&
    $stable(octant_o) && $stable(edge_x_o) && $stable(edge_y_o) && $stable(last_o))
    else $error("stalled result changed");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_EMPTY) |-> last_o && (octant_o == '0) &&
    (edge_x_o == '0) && (edge_y_o == '0) && (out_colour_o == '0))
    else $error("empty result not final or not cleared");

  a_pixel_no_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_PIXEL) |-> (to_x_o == '0) && (to_y_o == '0))
    else $error("pixel result carries a line end");

  a_octant_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o &&
    (octant_o > $past(octant_o)))
    else $error("octants not ascending within a step");

endmodule

bind midpoint_circle_arc_rasterizer_top mcar_checker u_mcar_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .kind_o      (kind_o),
  .octant_o    (octant_o),
  .edge_x_o    (edge_x_o),
  .edge_y_o    (edge_y_o),
  .to_x_o      (to_x_o),
  .to_y_o      (to_y_o),
  .out_colour_o(out_colour_o),
  .last_o      (last_o)
);

[dv/midpoint_circle_arc_rasterizer_top_tb.sv]
// Self-checking testbench for the midpoint circle arc rasterizer top level.
module midpoint_circle_arc_rasterizer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mcar_pkg::*;

  localparam int MaxRadius   = 1023;
  localparam int DrainCycles = 12;
  localparam int CycleLimit  = 400000;
  localparam int ItemsPerSet = 40;

  typedef struct {
    cmd_e                cmd;
    logic [CoordW-1:0]   cx;
    logic [CoordW-1:0]   cy;
    logic [CoordW-1:0]   radius;
    logic [ColourW-1:0]  colour;
    logic                fill;
    logic [NumOct-1:0]   mask;
  } circle_item_t;

  typedef struct {
    kind_e               kind;
    logic [OctW-1:0]     octant;
    logic [EdgeW-1:0]    ex;
    logic [EdgeW-1:0]    ey;
    logic [CoordW-1:0]   tx;
    logic [CoordW-1:0]   ty;
    logic [ColourW-1:0]  colour;
    logic                last;
    logic                done;
  } draw_cmd_t;

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                psel       = 1'b0;
  logic                penable    = 1'b0;
  logic                pwrite     = 1'b0;
  logic [2:0]          paddr      = '0;
  logic [31:0]         pwdata     = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid   = 1'b0;
  logic                in_stall;
  logic                cmd        = 1'b0;
  logic [CoordW-1:0]   centre_x   = '0;
  logic [CoordW-1:0]   centre_y   = '0;
  logic [CoordW-1:0]   radius     = '0;
  logic [ColourW-1:0]  colour     = '0;
  logic                fill       = 1'b0;
  logic [NumOct-1:0]   oct_mask   = '0;
  logic                out_valid;
  logic                out_stall  = 1'b0;
  logic [1:0]          kind;
  logic [OctW-1:0]     octant;
  logic [EdgeW-1:0]    edge_x;
  logic [EdgeW-1:0]    edge_y;
  logic [CoordW-1:0]   to_x;
  logic [CoordW-1:0]   to_y;
  logic [ColourW-1:0]  out_colour;
  logic                last;
  logic                done_res;

  // predicted circle state and clip limits
  logic [ClipW-1:0]    clip_x_lim = ClipMaxXReset;
  logic [ClipW-1:0]    clip_y_lim = ClipMaxYReset;
  logic [CoordW-1:0]   arc_cx     = '0;
  logic [CoordW-1:0]   arc_cy     = '0;
  int                  arc_x      = 0;
  int                  arc_y      = 0;
  int                  arc_dec    = 0;
  logic [ColourW-1:0]  arc_colour = '0;
  logic                arc_fill   = 1'b0;
  logic [NumOct-1:0]   arc_mask   = '0;
  logic                arc_done   = 1'b1;

  circle_item_t        pending[$];
  circle_item_t        cur_item;
  draw_cmd_t           expected_cmds[$];
  draw_cmd_t           got_cmd;
  draw_cmd_t           exp_cmd;
  int                  errors      = 0;
  int                  cycle_count = 0;
  int                  gap_left    = 0;
  int                  burst_left  = 0;
  int                  stall_mode  = 0;
  int                  stall_timer = 0;
  int                  stall_phase = 0;

  midpoint_circle_arc_rasterizer_top #(
    .MAX_RADIUS(MaxRadius)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .cmd_i        (cmd),
    .centre_x_i   (centre_x),
    .centre_y_i   (centre_y),
    .radius_i     (radius),
    .colour_i     (colour),
    .fill_i       (fill),
    .octant_mask_i(oct_mask),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .kind_o       (kind),
    .octant_o     (octant),
    .edge_x_o     (edge_x),
    .edge_y_o     (edge_y),
    .to_x_o       (to_x),
    .to_y_o       (to_y),
    .out_colour_o (out_colour),
    .last_o       (last),
    .done_res_o   (done_res)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic int wrap16(input int v);
    shortint s;
    s = shortint'(v);
    return int'(s);
  endfunction

  function automatic draw_cmd_t empty_cmd(input logic done);
    draw_cmd_t c;
    c.kind   = KIND_EMPTY;
    c.octant = '0;
    c.ex     = '0;
    c.ey     = '0;
    c.tx     = '0;
    c.ty     = '0;
    c.colour = '0;
    c.last   = 1'b0;
    c.done   = done;
    return c;
  endfunction

  // advance the predicted circle by one item and queue the commands it draws
  function automatic void step_arc(input circle_item_t it);
    int        px[8];
    int        py[8];
    int        cx;
    int        cy;
    int        r;
    bit        keep;
    draw_cmd_t c;
    draw_cmd_t batch[$];
    if (it.cmd == CMD_START) begin
      r = int'(it.radius);
      if (r > MaxRadius) r = MaxRadius;
      arc_cx     = it.cx;
      arc_cy     = it.cy;
      arc_colour = it.colour;
      arc_fill   = it.fill;
      arc_mask   = it.mask;
      arc_x      = 0;
      arc_y      = r;
      arc_dec    = wrap16(3 - 2 * r);
      arc_done   = 1'b0;
    end else if (arc_done) begin
      c = empty_cmd(1'b1);
      c.last = 1'b1;
      expected_cmds.push_back(c);
      return;
    end else begin
      arc_x = arc_x + 1;
      if (arc_dec > 0) begin
        arc_y   = arc_y - 1;
        arc_dec = wrap16(arc_dec + 4 * (arc_x - arc_y) + 10);
      end else begin
        arc_dec = wrap16(arc_dec + 4 * arc_x + 6);
      end
      arc_done = arc_y < arc_x;
    end
    cx = int'(arc_cx);
    cy = int'(arc_cy);
    px[0] = cx + arc_x; py[0] = cy + arc_y;
    px[1] = cx - arc_x; py[1] = cy + arc_y;
    px[2] = cx + arc_x; py[2] = cy - arc_y;
    px[3] = cx - arc_x; py[3] = cy - arc_y;
    px[4] = cx - arc_y; py[4] = cy - arc_x;
    px[5] = cx + arc_y; py[5] = cy - arc_x;
    px[6] = cx - arc_y; py[6] = cy + arc_x;
    px[7] = cx + arc_y; py[7] = cy + arc_x;
    for (int k = 0; k < 8; k++) begin
      if (arc_mask[k]) begin
        c        = empty_cmd(arc_done);
        c.octant = 3'(k);
        c.ex     = 12'(px[k]);
        c.ey     = 12'(py[k]);
        c.colour = arc_colour;
        if (arc_fill) begin
          keep = px[k] >= 0 && px[k] <= int'(clip_x_lim) &&
                 py[k] >= 0 && py[k] <= int'(clip_y_lim) &&
                 cx <= int'(clip_x_lim) && cy <= int'(clip_y_lim);
          c.kind = KIND_LINE;
          c.tx   = arc_cx;
          c.ty   = arc_cy;
          if (keep) batch.push_back(c);
        end else begin
          c.kind = KIND_PIXEL;
          batch.push_back(c);
        end
      end
    end
    if (batch.size() == 0) batch.push_back(empty_cmd(arc_done));
    batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) expected_cmds.push_back(batch[i]);
  endfunction

  function automatic bit cmd_matches(input draw_cmd_t e, input draw_cmd_t g);
    return e.kind === g.kind && e.octant === g.octant && e.ex === g.ex &&
           e.ey === g.ey && e.tx === g.tx && e.ty === g.ty &&
           e.colour === g.colour && e.last === g.last && e.done === g.done;
  endfunction

  function automatic void show_cmd(input string tag, input draw_cmd_t c);
    $display("  %s kind=%0d oct=%0d edge=(%0d,%0d) to=(%0d,%0d) col=%0d last=%0b done=%0b",
             tag, c.kind, c.octant, $signed(c.ex), $signed(c.ey), c.tx, c.ty,
             c.colour, c.last, c.done);
  endfunction

  // sender: bursts of items with random gaps, payload held while stalled
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) step_arc(cur_item);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending.size() != 0) begin
          cur_item = pending.pop_front();
          in_valid <= 1'b1;
          cmd      <= cur_item.cmd;
          centre_x <= cur_item.cx;
          centre_y <= cur_item.cy;
          radius   <= cur_item.radius;
          colour   <= cur_item.colour;
          fill     <= cur_item.fill;
          oct_mask <= cur_item.mask;
          if (burst_left > 0) begin
            burst_left = burst_left - 1;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern switches between none, random and periodic
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (stall_timer == 0) begin
        stall_mode  = $urandom_range(0, 2);
        stall_timer = $urandom_range(20, 150);
      end else begin
        stall_timer = stall_timer - 1;
      end
      stall_phase = (stall_phase + 1) % 7;
      case (stall_mode)
        0: begin
          out_stall <= 1'b0;
        end
        1: begin
          out_stall <= ($urandom_range(0, 2) == 0);
        end
        default: begin
          out_stall <= (stall_phase < 3);
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      got_cmd.kind   = kind_e'(kind);
      got_cmd.octant = octant;
      got_cmd.ex     = edge_x;
      got_cmd.ey     = edge_y;
      got_cmd.tx     = to_x;
      got_cmd.ty     = to_y;
      got_cmd.colour = out_colour;
      got_cmd.last   = last;
      got_cmd.done   = done_res;
      if (expected_cmds.size() == 0) begin
        errors = errors + 1;
        if (errors <= 10) begin
          $display("unexpected command at cycle %0d", cycle_count);
          show_cmd("got", got_cmd);
        end
      end else begin
        exp_cmd = expected_cmds.pop_front();
        if (!cmd_matches(exp_cmd, got_cmd)) begin
          errors = errors + 1;
          if (errors <= 10) begin
            $display("command mismatch at cycle %0d", cycle_count);
            show_cmd("exp", exp_cmd);
            show_cmd("got", got_cmd);
          end
        end
      end
    end
  end

  function automatic circle_item_t start_item(input int x, input int y, input int r,
                                              input int col, input bit f, input int m);
    circle_item_t it;
    it.cmd    = CMD_START;
    it.cx     = 10'(x);
    it.cy     = 10'(y);
    it.radius = 10'(r);
    it.colour = 6'(col);
    it.fill   = f;
    it.mask   = 8'(m);
    return it;
  endfunction

  function automatic circle_item_t advance_item();
    circle_item_t it;
    it     = start_item($urandom_range(0, 1023), $urandom_range(0, 1023),
                        $urandom_range(0, 1023), $urandom_range(0, 63),
                        $urandom_range(0, 1), $urandom_range(0, 255));
    it.cmd = CMD_ADVANCE;
    return it;
  endfunction

  function automatic int pick_centre(input int lim);
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, 1023);
    return $urandom_range(0, (lim + 4 > 1023) ? 1023 : lim + 4);
  endfunction

  task automatic queue_random_items(input int count);
    int           added;
    int           r;
    int           steps;
    circle_item_t it;
    added = 0;
    while (added < count) begin
      if ($urandom_range(0, 6) == 0) begin
        it     = advance_item();
        it.cmd = cmd_e'($urandom_range(0, 1));
        pending.push_back(it);
        added = added + 1;
      end else begin
        case ($urandom_range(0, 9))
          0: begin
            r = $urandom_range(0, 1023);
          end
          1, 2: begin
            r = $urandom_range(25, 200);
          end
          default: begin
            r = $urandom_range(0, 24);
          end
        endcase
        it = start_item(pick_centre(int'(clip_x_lim)), pick_centre(int'(clip_y_lim)), r,
                        $urandom_range(0, 63), $urandom_range(0, 1),
                        ($urandom_range(0, 4) < 2) ? 8'hFF : $urandom_range(0, 255));
        pending.push_back(it);
        steps = (r > 40) ? $urandom_range(1, 40) : $urandom_range(1, r * 3 / 4 + 3);
        repeat (steps) pending.push_back(advance_item());
        added = added + 1 + steps;
      end
    end
  endtask

  task automatic wait_idle();
    while (pending.size() != 0 || in_valid || expected_cmds.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_clip(input reg_e idx, input logic [ClipW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_CLIP_MAX_X) clip_x_lim = value;
    else clip_y_lim = value;
  endtask

  initial begin
    while (cycle_count < CycleLimit) @(posedge clk_i);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    pending.push_back(advance_item());
    pending.push_back(start_item(0, 0, 0, 63, 1'b0, 8'hFF));
    pending.push_back(advance_item());
    pending.push_back(advance_item());
    pending.push_back(start_item(1023, 1023, 1023, 0, 1'b0, 8'hFF));
    pending.push_back(start_item(0, 0, 1023, 21, 1'b0, 8'hFF));
    pending.push_back(advance_item());
    pending.push_back(start_item(400, 240, 5, 42, 1'b1, 8'hFF));
    repeat (3) pending.push_back(advance_item());
    pending.push_back(start_item(900, 100, 3, 7, 1'b1, 8'hFF));
    pending.push_back(advance_item());
    pending.push_back(start_item(10, 10, 2, 9, 1'b1, 8'h00));
    pending.push_back(start_item(20, 20, 4, 1, 1'b0, 8'h01));
    pending.push_back(start_item(20, 20, 4, 2, 1'b0, 8'h80));
    pending.push_back(start_item(20, 20, 4, 3, 1'b0, 8'hAA));
    pending.push_back(start_item(2, 2, 5, 44, 1'b1, 8'hFF));
    pending.push_back(advance_item());
    pending.push_back(start_item(800, 480, 0, 55, 1'b1, 8'hFF));
    pending.push_back(start_item(800, 480, 1, 56, 1'b1, 8'hFF));
    pending.push_back(advance_item());
    wait_idle();

    for (int set = 0; set < 5; set++) begin
      case (set)
        1: begin
          write_clip(REG_CLIP_MAX_X, 11'd2047);
          write_clip(REG_CLIP_MAX_Y, 11'd2047);
        end
        2: begin
          write_clip(REG_CLIP_MAX_X, 11'd0);
          write_clip(REG_CLIP_MAX_Y, 11'd0);
        end
        3: begin
          write_clip(REG_CLIP_MAX_X, 11'($urandom_range(0, 2047)));
          write_clip(REG_CLIP_MAX_Y, 11'($urandom_range(0, 2047)));
        end
        4: begin
          write_clip(REG_CLIP_MAX_X, 11'($urandom_range(50, 300)));
          write_clip(REG_CLIP_MAX_Y, 11'($urandom_range(50, 300)));
        end
        default: begin
        end
      endcase
      queue_random_items(ItemsPerSet);
      wait_idle();
    end

    errors = errors + expected_cmds.size();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/mcar_pkg.sv
hdl/mcar_front.sv
hdl/mcar_fifo.sv
hdl/mcar_back.sv
hdl/midpoint_circle_arc_rasterizer_top.sv
hdl/mcar_checker.sv
dv/midpoint_circle_arc_rasterizer_top_tb.sv
